### design/packed_sprite_record_validator_unit_defines.svh
// Assertion helpers for the packed sprite record validator.
// Both sample on the rising edge of clk and are off while rst_n is low.
`ifndef PACKED_SPRITE_RECORD_VALIDATOR_UNIT_DEFINES_SVH
`define PACKED_SPRITE_RECORD_VALIDATOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSRV_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSRV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/psrv_pkg.sv
`timescale 1ns / 1ps

package psrv_pkg;

    // Longest record that can be accepted, in bytes.
    localparam logic [15:0] MAX_RECORD_BYTES = 16'd32768;

    // Largest placed coordinate that still fits a signed 16-bit position.
    localparam logic signed [17:0] PLACE_LIMIT = 18'sd32767;

    // Index of the last of the eight bytes in one rectangle header.
    localparam logic [2:0] HDR_LAST_INDEX = 3'd7;

    // Parse position within a record.
    typedef enum logic [2:0] {
        PH_COUNT_LO = 3'd0,
        PH_COUNT_HI = 3'd1,
        PH_HEADER   = 3'd2,
        PH_PIXELS   = 3'd3,
        PH_DONE     = 3'd4
    } phase_t;

    // Verdict request handed from the parser to the checker.
    typedef struct packed {
        logic               pre_ok;
        logic [16:0]        max_right;
        logic [16:0]        max_bottom;
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
    } verdict_t;

    // Parser status seen by the top level.
    typedef struct packed {
        phase_t phase;
        logic   failed;
    } front_status_t;

    // Queue status.
    typedef struct packed {
        logic       full;
        logic       empty;
        logic [1:0] count;
    } queue_status_t;

endpackage

### design/packed_sprite_record_validator_unit.sv
`timescale 1ns / 1ps

// Packed sprite record validator. Records arrive one byte per request, the
// final byte flagged by last_byte; origin_x, origin_y and list_full are only
// looked at on that final byte, which alone produces a result: accepted plus
// the bounding width and height (zero when rejected). A byte is taken every
// cycle while in_ready is high, the figure being set by the parse update of
// the byte parser, which handles each byte as it is taken. The verdict
// request of a record's last byte is written into the queue, and the result
// is registered in the output register once that is free or being emptied.
// Verdicts wait in a two-entry queue ahead of the output register, so
// in_ready drops only when that queue is full, which needs a stalled output
// side. No clearing pass is needed after reset.
`include "packed_sprite_record_validator_unit_defines.svh"

module packed_sprite_record_validator_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         data_byte,
    input  logic               last_byte,
    input  logic signed [15:0] origin_x,
    input  logic signed [15:0] origin_y,
    input  logic               list_full,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               accepted,
    output logic [15:0]        bound_width,
    output logic [15:0]        bound_height
);
    import psrv_pkg::*;

    logic          byte_accept;
    logic          push;
    logic          pop;
    verdict_t      push_data;
    verdict_t      pop_data;
    front_status_t front_status;
    queue_status_t queue_status;

    // Bytes are taken as long as a verdict slot is free.
    assign in_ready    = !queue_status.full;
    assign byte_accept = in_valid && in_ready;

    psrv_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_accept (byte_accept),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .origin_x    (origin_x),
        .origin_y    (origin_y),
        .list_full   (list_full),
        .push        (push),
        .verdict     (push_data),
        .status      (front_status)
    );

    psrv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (queue_status)
    );

    psrv_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (!queue_status.empty),
        .req          (pop_data),
        .req_pop      (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .accepted     (accepted),
        .bound_width  (bound_width),
        .bound_height (bound_height)
    );

    // A rejected record never reports a bounding size.
    `PSRV_ASSERT_SAME(a_reject_zero_bounds, out_valid && !accepted,
        (bound_width == 16'd0) && (bound_height == 16'd0), "rejected result has nonzero bounds")

    // The verdict request of a last byte is waiting in the queue afterward.
    `PSRV_ASSERT_NEXT(a_last_queued, byte_accept && last_byte,
        !queue_status.empty, "verdict request of a last byte was lost")

    // After the last byte the parser is rearmed for a new record.
    `PSRV_ASSERT_NEXT(a_parser_rearmed, byte_accept && last_byte,
        (front_status.phase == PH_COUNT_LO) && !front_status.failed,
        "parser not rearmed after the last byte")

endmodule

### design/psrv_front.sv
`timescale 1ns / 1ps

module psrv_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    byte_accept,
    input  logic [7:0]              data_byte,
    input  logic                    last_byte,
    input  logic signed [15:0]      origin_x,
    input  logic signed [15:0]      origin_y,
    input  logic                    list_full,
    output logic                    push,
    output psrv_pkg::verdict_t      verdict,
    output psrv_pkg::front_status_t status
);
    import psrv_pkg::*;

    phase_t       phase_reg, phase_next;
    logic [2:0]   byte_index_reg, byte_index_next;
    logic [15:0]  bytes_seen_reg, bytes_seen_next;
    logic [15:0]  rects_left_reg, rects_left_next;
    logic [55:0]  hdr_reg, hdr_next;
    logic [15:0]  pixels_left_reg, pixels_left_next;
    logic [16:0]  max_right_reg, max_right_next;
    logic [16:0]  max_bottom_reg, max_bottom_next;
    logic         failed_reg, failed_next;

    logic [15:0]  hdr_dx;
    logic [15:0]  hdr_dy;
    logic [15:0]  hdr_w;
    logic [15:0]  hdr_h;
    logic [31:0]  area;
    logic [16:0]  right_edge;
    logic [16:0]  bottom_edge;
    logic [15:0]  pixels_dec;
    logic [15:0]  rects_dec;
    logic [15:0]  rects_full;

    // Header fields; the last header byte arrives on the data port.
    assign hdr_dx      = hdr_reg[15:0];
    assign hdr_dy      = hdr_reg[31:16];
    assign hdr_w       = hdr_reg[47:32];
    assign hdr_h       = {data_byte, hdr_reg[55:48]};
    assign area        = {16'd0, hdr_w} * {16'd0, hdr_h};
    assign right_edge  = {1'b0, hdr_dx} + {1'b0, hdr_w};
    assign bottom_edge = {1'b0, hdr_dy} + {1'b0, hdr_h};
    assign pixels_dec  = pixels_left_reg - 16'd1;
    assign rects_dec   = rects_left_reg - 16'd1;
    assign rects_full  = {data_byte, rects_left_reg[7:0]};

    // Per-byte parse step, and the verdict request on the last byte.
    always_comb
    begin
        phase_next       = phase_reg;
        byte_index_next  = byte_index_reg;
        bytes_seen_next  = bytes_seen_reg;
        rects_left_next  = rects_left_reg;
        hdr_next         = hdr_reg;
        pixels_left_next = pixels_left_reg;
        max_right_next   = max_right_reg;
        max_bottom_next  = max_bottom_reg;
        failed_next      = failed_reg;
        push             = 1'b0;
        verdict          = '0;

        if (byte_accept)
        begin
            // Length count saturates; a byte beyond the limit fails the record.
            if (bytes_seen_reg >= MAX_RECORD_BYTES)
            begin
                failed_next = 1'b1;
            end
            else
            begin
                bytes_seen_next = bytes_seen_reg + 16'd1;
            end

            if (!failed_next)
            begin
                unique case (phase_reg)
                    PH_COUNT_LO:
                    begin
                        rects_left_next = {8'd0, data_byte};
                        phase_next      = PH_COUNT_HI;
                    end
                    PH_COUNT_HI:
                    begin
                        rects_left_next = rects_full;
                        phase_next      = (rects_full == 16'd0) ? PH_DONE : PH_HEADER;
                        byte_index_next = 3'd0;
                    end
                    PH_HEADER:
                    begin
                        hdr_next        = {data_byte, hdr_reg[55:8]};
                        byte_index_next = byte_index_reg + 3'd1;
                        if (byte_index_reg == HDR_LAST_INDEX)
                        begin
                            // A zero size or an area beyond 16 bits is a bad header.
                            if ((hdr_w == 16'd0) || (hdr_h == 16'd0) || (|area[31:16]))
                            begin
                                failed_next = 1'b1;
                            end
                            else
                            begin
                                if (right_edge > max_right_reg)
                                begin
                                    max_right_next = right_edge;
                                end
                                if (bottom_edge > max_bottom_reg)
                                begin
                                    max_bottom_next = bottom_edge;
                                end
                                pixels_left_next = area[15:0];
                                phase_next       = PH_PIXELS;
                            end
                        end
                    end
                    PH_PIXELS:
                    begin
                        pixels_left_next = pixels_dec;
                        if (pixels_dec == 16'd0)
                        begin
                            rects_left_next = rects_dec;
                            phase_next      = (rects_dec == 16'd0) ? PH_DONE : PH_HEADER;
                            byte_index_next = 3'd0;
                        end
                    end
                    default:
                    begin
                        // Any byte after the last rectangle is a trailing byte.
                        failed_next = 1'b1;
                    end
                endcase
            end

            // The last byte issues a verdict request and rearms the parser.
            if (last_byte)
            begin
                push               = 1'b1;
                verdict.pre_ok     = !failed_next && (phase_next == PH_DONE)
                                     && (bytes_seen_next >= 16'd2) && !list_full;
                verdict.max_right  = max_right_next;
                verdict.max_bottom = max_bottom_next;
                verdict.origin_x   = origin_x;
                verdict.origin_y   = origin_y;

                phase_next       = PH_COUNT_LO;
                byte_index_next  = 3'd0;
                bytes_seen_next  = 16'd0;
                rects_left_next  = 16'd0;
                hdr_next         = '0;
                pixels_left_next = 16'd0;
                max_right_next   = 17'd0;
                max_bottom_next  = 17'd0;
                failed_next      = 1'b0;
            end
        end
    end

    // Parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_COUNT_LO;
            byte_index_reg  <= 3'd0;
            bytes_seen_reg  <= 16'd0;
            rects_left_reg  <= 16'd0;
            hdr_reg         <= '0;
            pixels_left_reg <= 16'd0;
            max_right_reg   <= 17'd0;
            max_bottom_reg  <= 17'd0;
            failed_reg      <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            byte_index_reg  <= byte_index_next;
            bytes_seen_reg  <= bytes_seen_next;
            rects_left_reg  <= rects_left_next;
            hdr_reg         <= hdr_next;
            pixels_left_reg <= pixels_left_next;
            max_right_reg   <= max_right_next;
            max_bottom_reg  <= max_bottom_next;
            failed_reg      <= failed_next;
        end
    end

    assign status.phase  = phase_reg;
    assign status.failed = failed_reg;

endmodule

### design/psrv_queue.sv
`timescale 1ns / 1ps

module psrv_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  psrv_pkg::verdict_t      push_data,
    input  logic                    pop,
    output psrv_pkg::verdict_t      pop_data,
    output psrv_pkg::queue_status_t status
);
    import psrv_pkg::*;

    verdict_t   entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    // Entry storage; only written on a push.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    assign pop_data     = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign status.count = count_reg;

endmodule

### design/psrv_back.sv
`timescale 1ns / 1ps

module psrv_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  psrv_pkg::verdict_t req,
    output logic               req_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               accepted,
    output logic [15:0]        bound_width,
    output logic [15:0]        bound_height
);
    import psrv_pkg::*;

    logic               out_valid_reg;
    logic               accepted_reg;
    logic [15:0]        bound_width_reg;
    logic [15:0]        bound_height_reg;
    logic signed [17:0] place_x;
    logic signed [17:0] place_y;
    logic               ok;

    // Placement check: origin plus extent must stay within signed 16 bits.
    assign place_x = $signed({2'b00, req.max_right[15:0]})
                     + $signed({{2{req.origin_x[15]}}, req.origin_x});
    assign place_y = $signed({2'b00, req.max_bottom[15:0]})
                     + $signed({{2{req.origin_y[15]}}, req.origin_y});

    assign ok = req.pre_ok && !req.max_right[16] && !req.max_bottom[16]
                && (place_x <= PLACE_LIMIT) && (place_y <= PLACE_LIMIT);

    // Take a request whenever the output register is free or being emptied.
    assign req_pop = req_valid && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (req_pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload; bounds are forced to zero on a rejection.
    always_ff @(posedge clk)
    begin
        if (req_pop)
        begin
            accepted_reg     <= ok;
            bound_width_reg  <= ok ? req.max_right[15:0] : 16'd0;
            bound_height_reg <= ok ? req.max_bottom[15:0] : 16'd0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign accepted     = accepted_reg;
    assign bound_width  = bound_width_reg;
    assign bound_height = bound_height_reg;

endmodule

### dv/packed_sprite_record_validator_unit_test.sv
`timescale 1ns / 1ps

module packed_sprite_record_validator_unit_test;

    import psrv_pkg::*;

    // One record verdict as it should appear on the result port.
    typedef struct {
        logic        acc;
        logic [15:0] width;
        logic [15:0] height;
    } bound_verdict_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         data_byte;
    logic               last_byte;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic               list_full;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               accepted;
    logic [15:0]        bound_width;
    logic [15:0]        bound_height;

    // Parser state mirrored by the testbench.
    phase_t      rec_phase;
    logic [3:0]  hdr_pos;
    int          seen_bytes;
    logic [15:0] rects_pending;
    logic [63:0] hdr_bytes;
    logic [15:0] pixels_pending;
    logic [16:0] widest_right;
    logic [16:0] lowest_bottom;
    logic        rec_failed;

    bound_verdict_t pending_verdicts[$];
    logic [7:0]     record_buf[$];

    int send_gap_pct = 20;
    int recv_gap_pct = 81;
    int bytes_sent = 0;
    int verdicts_seen = 0;
    int accepts_seen = 0;
    int mismatch_count = 0;

    packed_sprite_record_validator_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .origin_x     (origin_x),
        .origin_y     (origin_y),
        .list_full    (list_full),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .accepted     (accepted),
        .bound_width  (bound_width),
        .bound_height (bound_height)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The run is cut off if it hangs.
    initial
    begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Receiver back-pressure.
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_gap_pct);
    end

    // Compare every verdict against the oldest prediction.
    always @(posedge clk)
    begin : check_verdicts
        bound_verdict_t exp_v;
        if (rst_n && out_valid && out_ready)
        begin
            verdicts_seen++;
            if (pending_verdicts.size() == 0)
            begin
                $error("verdict with no record pending: accepted=%0d", accepted);
                mismatch_count++;
            end
            else
            begin
                exp_v = pending_verdicts.pop_front();
                if (exp_v.acc)
                    accepts_seen++;
                if (accepted !== exp_v.acc)
                begin
                    $error("accepted: expected %0d, got %0d", exp_v.acc, accepted);
                    mismatch_count++;
                end
                if (bound_width !== exp_v.width)
                begin
                    $error("bound_width: expected %0d, got %0d", exp_v.width, bound_width);
                    mismatch_count++;
                end
                if (bound_height !== exp_v.height)
                begin
                    $error("bound_height: expected %0d, got %0d", exp_v.height, bound_height);
                    mismatch_count++;
                end
            end
        end
    end

    // Return the mirrored parser to its start-of-record state.
    task automatic clear_record_state();
        rec_phase      = PH_COUNT_LO;
        hdr_pos        = '0;
        seen_bytes     = 0;
        rects_pending  = '0;
        hdr_bytes      = '0;
        pixels_pending = '0;
        widest_right   = '0;
        lowest_bottom  = '0;
        rec_failed     = 1'b0;
    endtask

    // Advance the mirrored parser by one byte; the final byte queues a verdict.
    task automatic predict_record_byte(input logic [7:0] b, input logic is_last,
                                       input logic signed [15:0] ox,
                                       input logic signed [15:0] oy,
                                       input logic full_flag);
        logic [15:0]    hx, hy, hw, hh;
        logic [31:0]    area;
        logic [16:0]    right, bottom;
        logic           ok;
        bound_verdict_t v;
        if (seen_bytes >= int'(MAX_RECORD_BYTES))
            rec_failed = 1'b1;
        else
            seen_bytes++;

        if (!rec_failed)
        begin
            case (rec_phase)
                PH_COUNT_LO:
                begin
                    rects_pending = {8'h00, b};
                    rec_phase = PH_COUNT_HI;
                end
                PH_COUNT_HI:
                begin
                    rects_pending[15:8] = b;
                    rec_phase = (rects_pending == 16'd0) ? PH_DONE : PH_HEADER;
                    hdr_pos = '0;
                    hdr_bytes = '0;
                end
                PH_HEADER:
                begin
                    hdr_bytes[hdr_pos[2:0]*8 +: 8] = b;
                    hdr_pos = hdr_pos + 4'd1;
                    if (hdr_pos == 4'd8)
                    begin
                        hx = hdr_bytes[15:0];
                        hy = hdr_bytes[31:16];
                        hw = hdr_bytes[47:32];
                        hh = hdr_bytes[63:48];
                        area = 32'(hw) * 32'(hh);
                        if (hw == 16'd0 || hh == 16'd0 || area > 32'd65535)
                            rec_failed = 1'b1;
                        else
                        begin
                            right = {1'b0, hx} + {1'b0, hw};
                            bottom = {1'b0, hy} + {1'b0, hh};
                            if (right > widest_right)
                                widest_right = right;
                            if (bottom > lowest_bottom)
                                lowest_bottom = bottom;
                            pixels_pending = area[15:0];
                            rec_phase = PH_PIXELS;
                        end
                    end
                end
                PH_PIXELS:
                begin
                    pixels_pending = pixels_pending - 16'd1;
                    if (pixels_pending == 16'd0)
                    begin
                        rects_pending = rects_pending - 16'd1;
                        rec_phase = (rects_pending == 16'd0) ? PH_DONE : PH_HEADER;
                        hdr_pos = '0;
                        hdr_bytes = '0;
                    end
                end
                default:
                    rec_failed = 1'b1;
            endcase
        end

        if (is_last)
        begin
            ok = !rec_failed && rec_phase == PH_DONE && seen_bytes >= 2 && !full_flag
                 && widest_right <= 17'd65535 && lowest_bottom <= 17'd65535
                 && int'(widest_right) + int'(ox) <= int'(PLACE_LIMIT)
                 && int'(lowest_bottom) + int'(oy) <= int'(PLACE_LIMIT);
            v.acc    = ok;
            v.width  = ok ? widest_right[15:0] : 16'd0;
            v.height = ok ? lowest_bottom[15:0] : 16'd0;
            pending_verdicts.push_back(v);
            clear_record_state();
        end
    endtask

    // Offer one request byte, with a random idle gap ahead of it.
    // Called just after a falling edge and returns just after one.
    task automatic send_byte(input logic [7:0] b, input logic is_last,
                             input logic signed [15:0] ox, input logic signed [15:0] oy,
                             input logic full_flag);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= is_last;
        origin_x  <= ox;
        origin_y  <= oy;
        list_full <= full_flag;
        do
            @(posedge clk);
        while (!in_ready);
        predict_record_byte(b, is_last, ox, oy, full_flag);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Stop sending until every predicted verdict has come back.
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_verdicts.size() != 0)
            @(negedge clk);
    endtask

    task automatic push16(input logic [15:0] v);
        record_buf.push_back(v[7:0]);
        record_buf.push_back(v[15:8]);
    endtask

    task automatic start_record(input logic [15:0] count);
        record_buf.delete();
        push16(count);
    endtask

    // Append one rectangle header followed by npix random pixel bytes.
    task automatic add_rect(input logic [15:0] dx, input logic [15:0] dy,
                            input logic [15:0] w, input logic [15:0] h, input int npix);
        push16(dx);
        push16(dy);
        push16(w);
        push16(h);
        for (int i = 0; i < npix; i++)
            record_buf.push_back(8'($urandom));
    endtask

    // Send the buffered record; origins and list_full only matter on its last byte,
    // so the other bytes carry random values there.
    task automatic send_record(input logic signed [15:0] ox, input logic signed [15:0] oy,
                               input logic full_flag);
        int n;
        n = record_buf.size();
        for (int i = 0; i < n; i++)
        begin
            if (i == n - 1)
                send_byte(record_buf[i], 1'b1, ox, oy, full_flag);
            else
                send_byte(record_buf[i], 1'b0, 16'($urandom), 16'($urandom), 1'($urandom));
        end
    endtask

    function automatic logic signed [15:0] pick_origin();
        int t;
        if ($urandom_range(9) == 0)
            t = int'($urandom_range(65535));
        else
            t = int'($urandom_range(2000)) - 1000;
        return 16'(t);
    endfunction

    // A well-formed record of up to three mostly small rectangles.
    task automatic build_valid_record();
        int n_rects, w, h, dx, dy;
        n_rects = $urandom_range(3);
        start_record(16'(n_rects));
        for (int r = 0; r < n_rects; r++)
        begin
            if ($urandom_range(9) == 0)
            begin
                w = $urandom_range(1, 200);
                h = 1;
            end
            else
            begin
                w = $urandom_range(1, 4);
                h = $urandom_range(1, 4);
            end
            dx = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(300);
            dy = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(300);
            add_rect(16'(dx), 16'(dy), 16'(w), 16'(h), w * h);
        end
    endtask

    // A record with no rectangles gives a zero-sized bound, at the lowest and the highest origin.
    task automatic test_count_only();
        start_record(16'd0);
        send_record(-16'sd32768, -16'sd32768, 1'b0);
        start_record(16'd0);
        send_record(16'sd32767, 16'sd32767, 1'b0);
    endtask

    // A single byte can never form a record.
    task automatic test_short_record();
        send_byte(8'hFF, 1'b1, 16'sd0, 16'sd0, 1'b0);
        send_byte(8'h00, 1'b1, 16'sd0, 16'sd0, 1'b0);
    endtask

    // One rectangle placed exactly at the coordinate limit, then one past it in x and one past it in y.
    task automatic test_placement_limit();
        start_record(16'd1);
        add_rect(16'd3, 16'd5, 16'd2, 16'd1, 2);
        send_record(16'sd32762, 16'sd32761, 1'b0);
        start_record(16'd1);
        add_rect(16'd3, 16'd5, 16'd2, 16'd1, 2);
        send_record(16'sd32763, 16'sd0, 1'b0);
        start_record(16'd1);
        add_rect(16'd3, 16'd5, 16'd2, 16'd1, 2);
        send_record(16'sd0, 16'sd32762, 1'b0);
    endtask

    // A full command list rejects an otherwise valid record.
    task automatic test_list_full();
        start_record(16'd0);
        send_record(16'sd0, 16'sd0, 1'b1);
    endtask

    // Zero or oversized rectangle headers fail, and the failure holds to the end.
    task automatic test_bad_header();
        start_record(16'd2);
        add_rect(16'd0, 16'd0, 16'd0, 16'd5, 0);
        add_rect(16'd1, 16'd1, 16'd1, 16'd1, 1);
        send_record(16'sd0, 16'sd0, 1'b0);
        start_record(16'd1);
        add_rect(16'd0, 16'd0, 16'd7, 16'd0, 0);
        send_record(16'sd0, 16'sd0, 1'b0);
        start_record(16'd1);
        add_rect(16'd0, 16'd0, 16'd256, 16'd256, 0);
        send_record(16'sd0, 16'sd0, 1'b0);
    endtask

    // Extents past 16 bits reject even with the lowest origin.
    task automatic test_extent_overflow();
        start_record(16'd1);
        add_rect(16'hFFFF, 16'd0, 16'd1, 16'd1, 1);
        send_record(-16'sd32768, -16'sd32768, 1'b0);
    endtask

    // A byte after the last rectangle, and a record cut short.
    task automatic test_trailing_and_truncated();
        start_record(16'd0);
        record_buf.push_back(8'hA5);
        send_record(16'sd0, 16'sd0, 1'b0);
        start_record(16'hFFFF);
        add_rect(16'd0, 16'd0, 16'd1, 16'd1, 1);
        send_record(16'sd0, 16'sd0, 1'b0);
    endtask

    // A negative origin pulls a wide rectangle back inside the limit.
    task automatic test_negative_origin();
        start_record(16'd1);
        add_rect(16'd40000, 16'd65534, 16'd1, 16'd1, 1);
        send_record(-16'sd32768, -16'sd32768, 1'b0);
    endtask

    // Mostly well-formed records, with truncated, padded, bad-header and noise records.
    task automatic test_random_records(input int byte_budget, input int min_verdicts,
                                       input int snd_pct, input int rcv_pct);
        int start_bytes, start_verdicts, kind, cut, extra;
        send_gap_pct = snd_pct;
        recv_gap_pct = rcv_pct;
        start_bytes = bytes_sent;
        start_verdicts = verdicts_seen;
        while (bytes_sent - start_bytes < byte_budget
               || verdicts_seen - start_verdicts < min_verdicts)
        begin
            kind = $urandom_range(99);
            if (kind < 88)
                build_valid_record();
            if (kind >= 70 && kind < 80 && record_buf.size() > 1)
            begin
                cut = $urandom_range(1, record_buf.size() - 1);
                repeat (cut)
                    void'(record_buf.pop_back());
            end
            else if (kind >= 80 && kind < 88)
            begin
                extra = $urandom_range(1, 3);
                repeat (extra)
                    record_buf.push_back(8'($urandom));
            end
            else if (kind >= 88 && kind < 94)
            begin
                start_record(16'($urandom_range(1, 3)));
                case ($urandom_range(2))
                    0: add_rect(16'($urandom), 16'($urandom), 16'd0,
                                16'($urandom), $urandom_range(4));
                    1: add_rect(16'($urandom), 16'($urandom), 16'($urandom),
                                16'd0, $urandom_range(4));
                    default: add_rect(16'($urandom), 16'($urandom), 16'd300, 16'd300,
                                      $urandom_range(4));
                endcase
            end
            else if (kind >= 94)
            begin
                record_buf.delete();
                extra = $urandom_range(1, 20);
                repeat (extra)
                    record_buf.push_back(8'($urandom));
            end
            send_record(pick_origin(), pick_origin(), ($urandom_range(9) == 0));
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        data_byte = '0;
        last_byte = 1'b0;
        origin_x  = '0;
        origin_y  = '0;
        list_full = 1'b0;
        clear_record_state();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_count_only();
        test_short_record();
        test_placement_limit();
        test_list_full();
        test_bad_header();
        test_extent_overflow();
        test_trailing_and_truncated();
        test_negative_origin();
        hold_until_drained();

        test_random_records(340, 15, 20, 81);
        hold_until_drained();
        test_random_records(340, 15, 81, 20);
        hold_until_drained();
        test_random_records(340, 15, 0, 0);

        // Let the last verdicts come back, then watch for strays.
        hold_until_drained();
        repeat (10) @(posedge clk);

        $display("Sent %0d request bytes; checked %0d record verdicts, %0d of them accepted.",
                 bytes_sent, verdicts_seen, accepts_seen);
        $display("Covered header faults, overflows, truncation, padding and a full list.");
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
